>>> hw/rtl/sha1s_pkg.sv
// Shared types and constants for the SHA-1 stream hasher.
`default_nettype none

package sha1s_pkg;

	typedef logic [31:0] word_t;

	localparam word_t H_INIT [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam word_t RND_K [4] = '{
		32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
	};

	localparam logic [7:0] PAD_BYTE      = 8'h80;
	localparam logic [5:0] IDX_LAST      = 6'd63;
	localparam logic [5:0] IDX_LEN_START = 6'd56;
	localparam logic [6:0] RND_GRP1      = 7'd20;
	localparam logic [6:0] RND_GRP2      = 7'd40;
	localparam logic [6:0] RND_GRP3      = 7'd60;
	localparam logic [6:0] RND_FOLD      = 7'd80;

	typedef enum logic [1:0] {
		SRC_DATA,
		SRC_PAD,
		SRC_ZERO,
		SRC_LEN
	} byte_src_t;

	typedef enum logic [2:0] {
		ST_ACCEPT,
		ST_FIN_WAIT,
		ST_PAD_MARK,
		ST_PAD_ZERO,
		ST_PAD_LEN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic      shift;
		byte_src_t src;
		logic      count;
		logic      reinit;
		logic      load_out;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic idx_last;
		logic idx_len;
		logic ovf;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

>>> hw/rtl/sha1s_core.sv
// SHA-1 compression unit: one round per cycle, rolling schedule window, chaining words.
`default_nettype none

module sha1s_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic         init,
	input  wire logic [511:0] blk,
	output logic              busy,
	output logic [159:0]      digest
);

	sha1s_pkg::word_t chain_q [5];
	sha1s_pkg::word_t w_q [16];
	sha1s_pkg::word_t a_q, b_q, c_q, d_q, e_q;
	logic [6:0]       rnd_q;
	logic             busy_q;

	sha1s_pkg::word_t f, k, t, w_new;

	always_comb begin
		if (rnd_q < sha1s_pkg::RND_GRP1) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = sha1s_pkg::RND_K[0];
		end else if (rnd_q < sha1s_pkg::RND_GRP2) begin
			f = b_q ^ c_q ^ d_q;
			k = sha1s_pkg::RND_K[1];
		end else if (rnd_q < sha1s_pkg::RND_GRP3) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = sha1s_pkg::RND_K[2];
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = sha1s_pkg::RND_K[3];
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + w_q[0] + k;
		w_new = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		w_new = {w_new[30:0], w_new[31]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= '0;
			for (int i = 0; i < 5; i++) begin
				chain_q[i] <= sha1s_pkg::H_INIT[i];
			end
		end else if (init) begin
			for (int i = 0; i < 5; i++) begin
				chain_q[i] <= sha1s_pkg::H_INIT[i];
			end
		end else if (start) begin
			busy_q <= 1'b1;
			rnd_q  <= '0;
		end else if (busy_q) begin
			if (rnd_q == sha1s_pkg::RND_FOLD) begin
				// fold the working words back into the chain
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
				busy_q     <= 1'b0;
			end else begin
				rnd_q <= rnd_q + 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= blk[511 - 32 * i -: 32];
			end
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (busy_q && rnd_q != sha1s_pkg::RND_FOLD) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= w_new;
			e_q <= d_q;
			d_q <= c_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			b_q <= a_q;
			a_q <= t;
		end
	end

	assign busy   = busy_q;
	assign digest = {chain_q[4], chain_q[3], chain_q[2], chain_q[1], chain_q[0]};

endmodule

`default_nettype wire

>>> hw/rtl/sha1s_dpath.sv
// Byte datapath: block shift buffer, byte index, length count, padding bytes, result register.
`default_nettype none

module sha1s_dpath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sha1s_pkg::cmd_t   cmd,
	output sha1s_pkg::status_t     status,
	input  wire logic [7:0]        data_byte,
	input  wire logic              core_busy,
	input  wire logic [159:0]      digest,
	output logic                   blk_start,
	output logic [511:0]           blk,
	input  wire logic              out_ready,
	output logic                   out_valid,
	output logic [159:0]           out_digest,
	output logic                   out_failed
);

	logic [511:0] buf_q;
	logic [5:0]   idx_q;
	logic [60:0]  cnt_q;
	logic         ovf_q;
	logic         out_valid_q;
	logic [159:0] out_digest_q;
	logic         out_failed_q;

	logic [7:0]   nbyte;
	logic [63:0]  len_sh;

	always_comb begin
		len_sh = {cnt_q, 3'b000} << {idx_q[2:0], 3'b000};
		case (cmd.src)
			sha1s_pkg::SRC_DATA: nbyte = data_byte;
			sha1s_pkg::SRC_PAD:  nbyte = sha1s_pkg::PAD_BYTE;
			sha1s_pkg::SRC_ZERO: nbyte = 8'h00;
			sha1s_pkg::SRC_LEN:  nbyte = len_sh[63:56];
			default:             nbyte = 8'h00;
		endcase
	end

	assign blk       = {buf_q[503:0], nbyte};
	assign blk_start = cmd.shift && (idx_q == sha1s_pkg::IDX_LAST);

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			buf_q <= blk;
		end
		if (cmd.load_out) begin
			out_digest_q <= ovf_q ? '0 : digest;
			out_failed_q <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.reinit) begin
				idx_q <= '0;
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				if (cmd.shift) begin
					idx_q <= idx_q + 6'd1;
				end
				if (cmd.count) begin
					cnt_q <= cnt_q + 61'd1;
					// count wraps to zero: latch the overflow
					if (&cnt_q) begin
						ovf_q <= 1'b1;
					end
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.busy     = core_busy;
	assign status.idx_last = (idx_q == sha1s_pkg::IDX_LAST);
	assign status.idx_len  = (idx_q == sha1s_pkg::IDX_LEN_START);
	assign status.ovf      = ovf_q;
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_digest = out_digest_q;
	assign out_failed = out_failed_q;

endmodule

`default_nettype wire

>>> hw/rtl/sha1s_ctrl.sv
// Controller: request intake, padding sequence and result hand-off.
`default_nettype none

module sha1s_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_last,
	input  wire logic                byte_valid,
	input  wire sha1s_pkg::status_t  status,
	output logic                     in_ready,
	output sha1s_pkg::cmd_t          cmd
);

	sha1s_pkg::state_t state_q, state_nxt;
	logic              step_ok;

	// a byte that closes a block must wait for the compression unit
	assign step_ok = !(status.busy && status.idx_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha1s_pkg::ST_ACCEPT;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			sha1s_pkg::ST_ACCEPT: begin
				if (in_valid && step_ok && in_last) begin
					state_nxt = sha1s_pkg::ST_FIN_WAIT;
				end
			end
			sha1s_pkg::ST_FIN_WAIT: begin
				if (!status.busy) begin
					state_nxt = status.ovf ? sha1s_pkg::ST_EMIT : sha1s_pkg::ST_PAD_MARK;
				end
			end
			sha1s_pkg::ST_PAD_MARK: begin
				if (step_ok) begin
					state_nxt = sha1s_pkg::ST_PAD_ZERO;
				end
			end
			sha1s_pkg::ST_PAD_ZERO: begin
				if (status.idx_len) begin
					state_nxt = sha1s_pkg::ST_PAD_LEN;
				end
			end
			sha1s_pkg::ST_PAD_LEN: begin
				if (step_ok && status.idx_last) begin
					state_nxt = sha1s_pkg::ST_DRAIN;
				end
			end
			sha1s_pkg::ST_DRAIN: begin
				if (!status.busy) begin
					state_nxt = sha1s_pkg::ST_EMIT;
				end
			end
			sha1s_pkg::ST_EMIT: begin
				if (status.out_free) begin
					state_nxt = sha1s_pkg::ST_ACCEPT;
				end
			end
			default: state_nxt = sha1s_pkg::ST_ACCEPT;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			sha1s_pkg::ST_ACCEPT: begin
				in_ready = step_ok;
				// drop bytes once the length count has overflowed
				if (in_valid && step_ok && byte_valid && !status.ovf) begin
					cmd.shift = 1'b1;
					cmd.count = 1'b1;
					cmd.src   = sha1s_pkg::SRC_DATA;
				end
			end
			sha1s_pkg::ST_PAD_MARK: begin
				if (step_ok) begin
					cmd.shift = 1'b1;
					cmd.src   = sha1s_pkg::SRC_PAD;
				end
			end
			sha1s_pkg::ST_PAD_ZERO: begin
				if (!status.idx_len && step_ok) begin
					cmd.shift = 1'b1;
					cmd.src   = sha1s_pkg::SRC_ZERO;
				end
			end
			sha1s_pkg::ST_PAD_LEN: begin
				if (step_ok) begin
					cmd.shift = 1'b1;
					cmd.src   = sha1s_pkg::SRC_LEN;
				end
			end
			sha1s_pkg::ST_EMIT: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					cmd.reinit   = 1'b1;
				end
			end
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> hw/rtl/sha1_stream_hasher.sv
// SHA-1 stream hasher: byte requests in, one digest request out per message.
//
// Input channel: one request per message byte on s_tdata, s_tuser set when the byte
// belongs to the message, s_tlast set on the request that ends the message.
// Output channel: one request per finished message, H0..H4 on m_tdata and m_tuser set
// when the 64-bit bit count overflowed (digest words are then zero).
// Throughput: a byte is taken every cycle while intake is open; each 64-byte block
// runs through an 80-round compression unit at one round per cycle, then a fold
// step adds the working words into the chaining words, beside intake. The byte that
// closes a block waits while the previous block is still compressing, so long
// messages stream at the pace of the compression unit.
// After the ending request the padding bytes go in one per cycle, a byte that closes a
// block waiting on the core, and one or two blocks compress (no padding on overflow).
// Reset clears the controller, counts and result valid flag and loads the initial
// chaining words. The result register holds a digest while m_tready is low; intake
// of the next message goes on and stalls only when its own digest is ready to load.
`default_nettype none

module sha1_stream_hasher (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // [7:0] data_byte
	input  wire logic         s_tuser,   // [0] byte_valid
	input  wire logic         s_tlast,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [159:0]      m_tdata,   // [31:0] digest_word0 .. [159:128] digest_word4
	output logic              m_tuser    // [0] failed
);

	sha1s_pkg::cmd_t    cmd;
	sha1s_pkg::status_t status;
	logic               core_busy;
	logic               blk_start;
	logic [511:0]       blk;
	logic [159:0]       digest;

	sha1s_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_last    (s_tlast),
		.byte_valid (s_tuser),
		.status     (status),
		.in_ready   (s_tready),
		.cmd        (cmd)
	);

	sha1s_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.data_byte  (s_tdata),
		.core_busy  (core_busy),
		.digest     (digest),
		.blk_start  (blk_start),
		.blk        (blk),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_digest (m_tdata),
		.out_failed (m_tuser)
	);

	sha1s_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (blk_start),
		.init   (cmd.reinit),
		.blk    (blk),
		.busy   (core_busy),
		.digest (digest)
	);

endmodule

`default_nettype wire

>>> sim/sha1_digest_checker.sv
// Checker for the SHA-1 stream hasher: predicts each digest from the byte requests and compares.
module sha1_digest_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [7:0]   s_tdata,   // [7:0] data_byte
	input  wire logic         s_tuser,   // [0] byte_valid
	input  wire logic         s_tlast,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [159:0] m_tdata,   // [31:0] digest_word0 .. [159:128] digest_word4
	input  wire logic         m_tuser,   // [0] failed
	output int                mismatches,
	output int                digests_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic         failed;
		logic [159:0] words;
	} digest_t;

	localparam logic [7:0] PAD_MARK  = 8'h80;
	localparam int         LEN_START = 56;

	logic [31:0] chain [5];
	logic [7:0]  blk [64];
	logic [5:0]  fill;
	logic [63:0] msg_bits;
	logic        len_overflow;
	digest_t     expected_digests [$];

	task automatic restart_hash();
		chain[0] = 32'h67452301;
		chain[1] = 32'hEFCDAB89;
		chain[2] = 32'h98BADCFE;
		chain[3] = 32'h10325476;
		chain[4] = 32'hC3D2E1F0;
		fill = '0;
		msg_bits = '0;
		len_overflow = 1'b0;
	endtask

	task automatic compress_block();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 16; i < 80; i++) begin
			t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
			w[i] = {t[30:0], t[31]};
		end
		a = chain[0];
		b = chain[1];
		c = chain[2];
		d = chain[3];
		e = chain[4];
		for (int r = 0; r < 80; r++) begin
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = 32'h5A827999;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = 32'h6ED9EBA1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = 32'h8F1BBCDC;
			end else begin
				f = b ^ c ^ d;
				k = 32'hCA62C1D6;
			end
			t = {a[26:0], a[31:27]} + f + e + w[r] + k;
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = t;
		end
		chain[0] = chain[0] + a;
		chain[1] = chain[1] + b;
		chain[2] = chain[2] + c;
		chain[3] = chain[3] + d;
		chain[4] = chain[4] + e;
	endtask

	task automatic note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s expected %08h got %08h", $time, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		int pos;
		digest_t want;
		if (!arst_n) begin
			restart_hash();
			expected_digests.delete();
			mismatches = 0;
			digests_owed = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				// bytes past a wrapped length are dropped until the message ends
				if (s_tuser && !len_overflow) begin
					blk[fill] = s_tdata;
					msg_bits = msg_bits + 64'd8;
					if (msg_bits == '0)
						len_overflow = 1'b1;
					fill = fill + 6'd1;
					if (fill == '0)
						compress_block();
				end
				if (s_tlast) begin
					if (len_overflow) begin
						want.failed = 1'b1;
						want.words = '0;
					end else begin
						pos = int'(fill);
						blk[pos] = PAD_MARK;
						pos++;
						// no room for the length: close this block and pad a fresh one
						if (pos > LEN_START) begin
							while (pos < 64) begin
								blk[pos] = '0;
								pos++;
							end
							compress_block();
							pos = 0;
						end
						while (pos < LEN_START) begin
							blk[pos] = '0;
							pos++;
						end
						for (int n = 0; n < 8; n++)
							blk[LEN_START+n] = msg_bits[63-8*n -: 8];
						compress_block();
						want.failed = 1'b0;
						want.words = {chain[4], chain[3], chain[2], chain[1], chain[0]};
					end
					expected_digests.push_back(want);
					restart_hash();
				end
			end
			if (m_tvalid && m_tready) begin
				if (expected_digests.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: digest request with none expected", $time);
				end else begin
					want = expected_digests.pop_front();
					for (int n = 0; n < 5; n++)
						if (m_tdata[32*n +: 32] !== want.words[32*n +: 32])
							note_mismatch($sformatf("digest_word%0d", n),
								want.words[32*n +: 32], m_tdata[32*n +: 32]);
					if (m_tuser !== want.failed)
						note_mismatch("failed", {31'd0, want.failed}, {31'd0, m_tuser});
				end
			end
			digests_owed = expected_digests.size();
		end
	end

endmodule

>>> sim/tb_top.sv
// Testbench top for the SHA-1 stream hasher: clock, reset, byte traffic, digest sink, verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int ITEM_TARGET  = 1400;
	localparam int MSG_TARGET   = 32;
	localparam int CALM_AFTER   = 1200;
	localparam int DRAIN_CYCLES = 250;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic [7:0]   s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         s_tlast = 1'b0;
	logic         m_tready = 1'b0;
	logic         s_tready;
	logic         m_tvalid;
	logic [159:0] m_tdata;
	logic         m_tuser;

	int mismatches;
	int digests_owed;
	int n_items = 0;
	int n_msgs = 0;
	int cycles = 0;
	int send_gap_pct = 0;
	int sink_stall_pct = 0;
	int stall_left = 0;
	bit calm = 1'b0;

	sha1_stream_hasher dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	sha1_digest_checker digest_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.mismatches   (mismatches),
		.digests_owed (digests_owed)
	);

	always #5ns clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// digest sink: stall in bursts of random length
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 99) < sink_stall_pct) begin
			stall_left = $urandom_range(0, 2);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_req(input logic [7:0] byte_in, input logic keep, input logic ends);
		int gap;
		gap = (!calm && $urandom_range(0, 99) < send_gap_pct) ? $urandom_range(1, 3) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= byte_in;
		s_tuser <= keep;
		s_tlast <= ends;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		n_items++;
		if (ends)
			n_msgs++;
		if (n_items >= CALM_AFTER)
			calm = 1'b1;
	endtask

	task automatic send_message(input int len, input bit byte_on_last);
		int sent;
		sent = 0;
		while (sent < len) begin
			if ($urandom_range(0, 99) < 6) begin
				send_req(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			end else begin
				sent++;
				send_req(8'($urandom_range(0, 255)), 1'b1, (sent == len) && byte_on_last);
			end
		end
		if (len == 0 || !byte_on_last)
			send_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	initial begin : stimulus
		int len;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty message, one-byte extremes, dropped fillers, "abc",
		// finish without a byte, back-to-back empties
		send_req(8'h5A, 1'b0, 1'b1);
		send_req(8'h00, 1'b1, 1'b1);
		send_req(8'hFF, 1'b1, 1'b1);
		send_req(8'hA5, 1'b0, 1'b0);
		send_req(8'h61, 1'b1, 1'b0);
		send_req(8'h62, 1'b1, 1'b0);
		send_req(8'h63, 1'b1, 1'b1);
		send_req(8'h3C, 1'b0, 1'b0);
		send_req(8'h7F, 1'b1, 1'b0);
		send_req(8'h80, 1'b1, 1'b0);
		send_req(8'h01, 1'b1, 1'b0);
		send_req(8'hFE, 1'b0, 1'b1);
		send_req(8'h00, 1'b0, 1'b1);
		send_req(8'hFF, 1'b0, 1'b1);
		// a wrapped length needs 2^61 bytes, far beyond any simulation run

		// random messages, weighted toward the padding and block boundaries
		while (n_items < ITEM_TARGET || n_msgs < MSG_TARGET) begin
			case ($urandom_range(0, 2))
				0: send_gap_pct = 0;
				1: send_gap_pct = 20;
				default: send_gap_pct = 50;
			endcase
			case ($urandom_range(0, 2))
				0: sink_stall_pct = 0;
				1: sink_stall_pct = 30;
				default: sink_stall_pct = 70;
			endcase
			case ($urandom_range(0, 9))
				0, 1, 2: len = $urandom_range(0, 3);
				3, 4: len = $urandom_range(54, 57);
				5: len = $urandom_range(62, 66);
				6: len = $urandom_range(118, 122);
				7: len = $urandom_range(126, 129);
				default: len = $urandom_range(0, 100);
			endcase
			send_message(len, 1'($urandom_range(0, 1)));
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (digests_owed != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && digests_owed == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> sha1_stream_hasher.f
hw/rtl/sha1s_pkg.sv
hw/rtl/sha1s_core.sv
hw/rtl/sha1s_dpath.sv
hw/rtl/sha1s_ctrl.sv
hw/rtl/sha1_stream_hasher.sv
sim/sha1_digest_checker.sv
sim/tb_top.sv
